// ===== hw/rtl/uvst_pkg.sv =====
// Shared types and codes for the unique value set table.
// Used by the engine, the top level and the checker.
`timescale 1ns / 1ps

package uvst_pkg;

  localparam logic [1:0] KIND_SEARCH = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam int VALUE_W = 32;
  localparam int OUT_W   = 7;

  typedef struct packed {
    logic [1:0]       status;
    logic [OUT_W-1:0] position;
    logic [OUT_W-1:0] entry_count;
  } res_t;

endpackage

// ===== hw/rtl/uvst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module uvst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/uvst_engine.sv =====
// Request sequencer: scans the entry RAM, appends, and compacts on delete.
// Depends on uvst_pkg and uvst_ram.
`timescale 1ns / 1ps

module uvst_engine
  import uvst_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         req_kind,
  input  logic [VALUE_W-1:0] req_value,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_RESOLVE = 3'd2;
  localparam logic [2:0] S_SHIFT   = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;

  logic [2:0]         state;
  logic [1:0]         kind;
  logic [VALUE_W-1:0] value;
  logic [AW-1:0]      ridx;
  logic [AW-1:0]      slot;
  logic               hit;
  logic [CW-1:0]      count;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [VALUE_W-1:0] rdata;

  uvst_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = value;
    raddr = '0;
    case (state)
      S_SCAN: begin
        raddr = ridx + AW'(1);
      end
      S_RESOLVE: begin
        raddr = slot + AW'(1);
        if (kind == KIND_INSERT && !hit && count < CW'(CAPACITY)) begin
          we = 1'b1;
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        waddr = ridx;
        wdata = rdata;
        raddr = ridx + AW'(2);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            kind  <= req_kind;
            value <= req_value;
            ridx  <= '0;
            hit   <= 1'b0;
            state <= (count == '0) ? S_RESOLVE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rdata == value) begin
            hit   <= 1'b1;
            slot  <= ridx;
            state <= S_RESOLVE;
          end else if (CW'(ridx) + CW'(1) == count) begin
            state <= S_RESOLVE;
          end else begin
            ridx <= ridx + AW'(1);
          end
        end
        S_RESOLVE: begin
          case (kind)
            KIND_INSERT: begin
              if (hit) begin
                res.status      <= ST_PRESENT;
                res.position    <= OUT_W'(slot) + OUT_W'(1);
                res.entry_count <= OUT_W'(count);
              end else if (count >= CW'(CAPACITY)) begin
                res.status      <= ST_FULL;
                res.position    <= '0;
                res.entry_count <= OUT_W'(count);
              end else begin
                res.status      <= ST_OK;
                res.position    <= OUT_W'(count) + OUT_W'(1);
                res.entry_count <= OUT_W'(count) + OUT_W'(1);
                count           <= count + CW'(1);
              end
              state <= S_DONE;
            end
            KIND_DELETE: begin
              if (hit) begin
                res.status   <= ST_OK;
                res.position <= OUT_W'(slot) + OUT_W'(1);
                if (CW'(slot) + CW'(1) < count) begin
                  ridx  <= slot;
                  state <= S_SHIFT;
                end else begin
                  res.entry_count <= OUT_W'(count) - OUT_W'(1);
                  count           <= count - CW'(1);
                  state           <= S_DONE;
                end
              end else begin
                res.status      <= ST_ABSENT;
                res.position    <= '0;
                res.entry_count <= OUT_W'(count);
                state           <= S_DONE;
              end
            end
            default: begin
              res.status      <= hit ? ST_OK : ST_ABSENT;
              res.position    <= hit ? OUT_W'(slot) + OUT_W'(1) : '0;
              res.entry_count <= OUT_W'(count);
              state           <= S_DONE;
            end
          endcase
        end
        S_SHIFT: begin
          if (CW'(ridx) + CW'(2) == count) begin
            res.entry_count <= OUT_W'(count) - OUT_W'(1);
            count           <= count - CW'(1);
            state           <= S_DONE;
          end else begin
            ridx <= ridx + AW'(1);
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/unique_value_set_table.sv =====
// Top level of the unique value set table: stream ports and result register.
// Depends on uvst_pkg and uvst_engine.
//
// A set of distinct 32-bit values held in insertion order in a single-port-read
// RAM of CAPACITY words. One request word is taken at a time. A search or insert
// of an absent value compares every stored entry, since the scan reads the entry
// RAM one word a cycle; a hit ends the scan early. A delete that hits then moves
// each entry above the match down through the same read port. The RAM needs no
// clearing after reset; only entries below the count are ever used. A result
// waits in an output register so the next request can be taken while it is
// pending.
`timescale 1ns / 1ps

module unique_value_set_table
  import uvst_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // value (signed)
  input  logic [1:0]  s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // position[6:0], entry_count[13:7], zero pad
  output logic [1:0]  m_tuser   // status
);

  logic res_valid;
  logic res_take;
  res_t res;
  res_t out_res;

  uvst_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_kind  (s_tuser),
    .req_value (s_tdata),
    .res_valid (res_valid),
    .res_ready (res_take),
    .res       (res)
  );

  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.entry_count, out_res.position};
  assign m_tuser = out_res.status;

endmodule

// ===== hw/rtl/uvst_checker.sv =====
// Port-level checks on result words of the unique value set table.
// Depends on uvst_pkg; bound to unique_value_set_table.
`timescale 1ns / 1ps

module uvst_checker
  import uvst_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_absent_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_ABSENT |-> m_tdata[6:0] == '0)
    else $error("absent result with nonzero position");

  a_full_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> m_tdata[6:0] == '0)
    else $error("full result with nonzero position");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> m_tdata[13:7] == OUT_W'(CAPACITY))
    else $error("full result with count below capacity");

endmodule

bind unique_value_set_table uvst_checker #(.CAPACITY(CAPACITY)) u_checker (.*);
